[hw/rtl/fbm_pkg.sv]
`timescale 1ns / 1ps

package fbm_pkg;

  // Storage geometry shared by the top level and the free FIFO.
  localparam int DEPTH = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int NUM_BUFFERS_DEF = 4;

  // Command codes carried on the input channel.
  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PRESENT = 2'd2
  } cmd_t;

  // Outcome codes carried on the result channel.
  typedef enum logic [1:0] {
    OUT_NEW      = 2'd0,
    OUT_REPEAT   = 2'd1,
    OUT_NONE     = 2'd2,
    OUT_RELEASED = 2'd3
  } outcome_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAKE,
    ST_PICK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Control from the sequencer to the free FIFO.
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

endpackage

[hw/rtl/fbm_free_fifo.sv]
`timescale 1ns / 1ps

module fbm_free_fifo #(
  parameter int NUM_BUFFERS = fbm_pkg::NUM_BUFFERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fbm_pkg::fifo_ctl_t        ctl,
  input  logic [fbm_pkg::IDX_W-1:0] push_data,
  output logic [fbm_pkg::IDX_W-1:0] head_data,
  output logic [fbm_pkg::CNT_W-1:0] count
);
  import fbm_pkg::*;

  logic [IDX_W-1:0] entry_r [DEPTH];
  logic [IDX_W-1:0] head_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] tail;
  logic             push_ok;

  // A push into a full FIFO is dropped.
  assign push_ok   = ctl.push && !count_r[CNT_W-1];
  assign tail      = head_r + count_r[IDX_W-1:0];
  assign head_data = entry_r[head_r];
  assign count     = count_r;

  // Pointer and fill count; after reset the FIFO holds every buffer in order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= CNT_W'(NUM_BUFFERS);
    end else begin
      if (ctl.pop) begin
        head_r <= head_r + IDX_W'(1);
      end
      count_r <= count_r + CNT_W'(push_ok) - CNT_W'(ctl.pop);
    end
  end

  // Entry storage; the entries beyond the buffer count are written before use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        entry_r[i] <= IDX_W'(i);
      end
    end else if (push_ok) begin
      entry_r[tail] <= push_data;
    end
  end

endmodule

[hw/rtl/frame_buffer_mailbox.sv]
`timescale 1ns / 1ps

// Swap-chain mailbox for NUM_BUFFERS frame buffers. Each command beat yields
// exactly one result beat. A release, a plain acquire and a present with
// nothing pending go straight to the done state; an acquire that reclaims a
// pending buffer passes the take state first, and a keep-all present the pick
// state. A latest-wins present passes the pick state and, if older buffers are
// pending, the drain state, because the pending list lives in a memory with a
// single read port and the sequencer reads one entry per cycle while it moves
// the stale buffers back to the free FIFO. A new command is taken once the
// previous result has entered the output register, so a result waiting on the
// output does not hold up the next command's work. The mode register may be
// written at any time the block is idle; there is no clearing pass after reset.
module frame_buffer_mailbox #(
  parameter int NUM_BUFFERS = fbm_pkg::NUM_BUFFERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_keep_all_mode,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_cmd,
  input  logic [fbm_pkg::IDX_W-1:0] in_buffer_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [fbm_pkg::IDX_W-1:0] out_granted_index,
  output logic [1:0]                out_outcome
);
  import fbm_pkg::*;

  state_t           state_r, state_nxt;
  logic             keep_all_r;

  logic [IDX_W-1:0] pend_mem [DEPTH];
  logic [IDX_W-1:0] pend_rdata_r;
  logic [IDX_W-1:0] rd_addr;
  logic             pend_we;
  logic [IDX_W-1:0] pend_waddr;

  logic [IDX_W-1:0] phead_r, phead_nxt;
  logic [CNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [IDX_W-1:0] shown_r, shown_nxt;
  logic             shown_valid_r, shown_valid_nxt;
  logic [IDX_W-1:0] drain_r, drain_nxt;
  logic [IDX_W-1:0] res_grant_r, res_grant_nxt;
  outcome_t         res_outcome_r, res_outcome_nxt;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_grant_r;
  outcome_t         out_outcome_r;
  logic             out_load;

  fifo_ctl_t        free_ctl;
  logic [IDX_W-1:0] free_push_data;
  logic [IDX_W-1:0] free_head;
  logic [CNT_W-1:0] free_cnt;

  logic             in_fire;
  logic             idx_ok;
  logic [CNT_W-1:0] pcnt_less2;

  assign cfg_ready         = 1'b1;
  assign in_ready          = (state_r == ST_IDLE);
  assign in_fire           = in_valid && in_ready;
  assign out_valid         = out_valid_r;
  assign out_granted_index = out_grant_r;
  assign out_outcome       = out_outcome_r;
  assign out_load          = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign idx_ok            = {1'b0, in_buffer_index} < CNT_W'(NUM_BUFFERS);
  assign pcnt_less2        = pcnt_r - CNT_W'(2);

  fbm_free_fifo #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_free_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (free_ctl),
    .push_data(free_push_data),
    .head_data(free_head),
    .count    (free_cnt)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if ((in_cmd == CMD_PRESENT) && (pcnt_r != '0)) begin
            state_nxt = ST_PICK;
          end else if ((in_cmd == CMD_ACQUIRE) && (free_cnt == '0) && !keep_all_r &&
                       (pcnt_r != '0)) begin
            state_nxt = ST_TAKE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_TAKE: state_nxt = ST_DONE;
      ST_PICK: begin
        if (!keep_all_r && (pcnt_r > CNT_W'(1))) begin
          state_nxt = ST_DRAIN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DRAIN: begin
        if (drain_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control: list updates, memory accesses and the pending result.
  always_comb begin
    phead_nxt       = phead_r;
    pcnt_nxt        = pcnt_r;
    shown_nxt       = shown_r;
    shown_valid_nxt = shown_valid_r;
    drain_nxt       = drain_r;
    res_grant_nxt   = res_grant_r;
    res_outcome_nxt = res_outcome_r;
    rd_addr         = phead_r;
    pend_we         = 1'b0;
    pend_waddr      = phead_r + pcnt_r[IDX_W-1:0];
    free_ctl        = '0;
    free_push_data  = pend_rdata_r;
    unique case (state_r)
      ST_IDLE: begin
        free_push_data = shown_r;
        if (in_fire) begin
          res_grant_nxt   = '0;
          res_outcome_nxt = OUT_NONE;
          unique case (cmd_t'(in_cmd))
            CMD_ACQUIRE: begin
              // The oldest free buffer; a pending one is reclaimed in the next state.
              if (free_cnt != '0) begin
                free_ctl.pop    = 1'b1;
                res_grant_nxt   = free_head;
                res_outcome_nxt = OUT_NEW;
              end
            end
            CMD_RELEASE: begin
              if (idx_ok && !pcnt_r[CNT_W-1]) begin
                pend_we         = 1'b1;
                pcnt_nxt        = pcnt_r + CNT_W'(1);
                res_outcome_nxt = OUT_RELEASED;
              end
            end
            CMD_PRESENT: begin
              if (pcnt_r == '0) begin
                if (!keep_all_r && shown_valid_r) begin
                  res_grant_nxt   = shown_r;
                  res_outcome_nxt = OUT_REPEAT;
                end
              end else begin
                // Recycle the shown buffer and fetch the one to show next.
                free_ctl.push = shown_valid_r;
                if (!keep_all_r) begin
                  rd_addr = phead_r + pcnt_r[IDX_W-1:0] - IDX_W'(1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_TAKE: begin
        res_grant_nxt   = pend_rdata_r;
        res_outcome_nxt = OUT_NEW;
        phead_nxt       = phead_r + IDX_W'(1);
        pcnt_nxt        = pcnt_r - CNT_W'(1);
      end
      ST_PICK: begin
        shown_nxt       = pend_rdata_r;
        shown_valid_nxt = 1'b1;
        res_grant_nxt   = pend_rdata_r;
        res_outcome_nxt = OUT_NEW;
        if (keep_all_r) begin
          phead_nxt = phead_r + IDX_W'(1);
          pcnt_nxt  = pcnt_r - CNT_W'(1);
        end else if (pcnt_r > CNT_W'(1)) begin
          // Start draining the older entries, newest first.
          drain_nxt = pcnt_less2[IDX_W-1:0];
          rd_addr   = phead_r + pcnt_less2[IDX_W-1:0];
        end else begin
          pcnt_nxt = '0;
        end
      end
      ST_DRAIN: begin
        free_ctl.push = 1'b1;
        if (drain_r == '0) begin
          pcnt_nxt = '0;
        end else begin
          drain_nxt = drain_r - IDX_W'(1);
          rd_addr   = phead_r + drain_r - IDX_W'(1);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      keep_all_r    <= 1'b0;
      phead_r       <= '0;
      pcnt_r        <= '0;
      shown_r       <= '0;
      shown_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      phead_r       <= phead_nxt;
      pcnt_r        <= pcnt_nxt;
      shown_r       <= shown_nxt;
      shown_valid_r <= shown_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        keep_all_r <= cfg_keep_all_mode;
      end
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    drain_r       <= drain_nxt;
    res_grant_r   <= res_grant_nxt;
    res_outcome_r <= res_outcome_nxt;
  end

  // Pending list memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_waddr] <= in_buffer_index;
    end
    pend_rdata_r <= pend_mem[rd_addr];
  end

  // Output register holding one result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_grant_r   <= res_grant_r;
      out_outcome_r <= res_outcome_r;
    end
  end

endmodule
